// ===== hdl/fbc_pkg.sv =====
// Shared constants and types for the frustum box cull unit.
// Depends on nothing; every other file but fbc_out_if imports it.
package fbc_pkg;

	localparam int COORD_W  = 32;
	localparam int PLANE_W  = COORD_W + 1;
	localparam int PROD_W   = PLANE_W + COORD_W;
	localparam int PSUM_W   = PROD_W + 1;
	localparam int TOTAL_W  = PSUM_W + 1;
	localparam int FRAC_W   = 16;
	localparam int N_PLANES = 6;
	localparam int N_ROWS   = 4;
	localparam int N_COLS   = 4;
	localparam int N_AXES   = 3;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_TEST = 1'b1;

	typedef logic [COORD_W-1:0] word_t;
	typedef logic [N_ROWS-1:0][N_COLS-1:0][COORD_W-1:0] matrix_t;
	typedef logic [N_PLANES-1:0][N_COLS-1:0][PLANE_W-1:0] plane_set_t;

	typedef struct packed {
		logic [N_AXES-1:0][COORD_W-1:0] lo;
		logic [N_AXES-1:0][COORD_W-1:0] hi;
	} box_t;

	typedef logic [N_PLANES-1:0][PSUM_W-1:0] psum_set_t;

	typedef struct packed {
		logic en1;
		logic en2;
		logic en3;
	} adv_t;

	typedef struct packed {
		logic v1;
		logic v2;
		logic v3;
	} stage_valid_t;

endpackage

// ===== hdl/fbc_in_if.sv =====
// Input channel: valid/ready handshake carrying a matrix row load or a box test.
// Depends on fbc_pkg.
interface fbc_in_if;
	import fbc_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      kind;
	logic [1:0]                row_index;
	logic signed [COORD_W-1:0] row_coeff_0;
	logic signed [COORD_W-1:0] row_coeff_1;
	logic signed [COORD_W-1:0] row_coeff_2;
	logic signed [COORD_W-1:0] row_coeff_3;
	logic signed [COORD_W-1:0] box_min_x;
	logic signed [COORD_W-1:0] box_min_y;
	logic signed [COORD_W-1:0] box_min_z;
	logic signed [COORD_W-1:0] box_max_x;
	logic signed [COORD_W-1:0] box_max_y;
	logic signed [COORD_W-1:0] box_max_z;

	modport source (
		output valid, kind, row_index, row_coeff_0, row_coeff_1, row_coeff_2, row_coeff_3,
		output box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
		input  ready
	);
	modport sink (
		input  valid, kind, row_index, row_coeff_0, row_coeff_1, row_coeff_2, row_coeff_3,
		input  box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
		output ready
	);

endinterface

// ===== hdl/fbc_out_if.sv =====
// Output channel: valid/ready handshake carrying one visibility flag.
// No dependencies.
interface fbc_out_if;

	logic valid;
	logic ready;
	logic visible;

	modport source (output valid, visible, input ready);
	modport sink (input valid, visible, output ready);

endinterface

// ===== hdl/fbc_plane_store.sv =====
// Matrix row storage and clip plane formation (row3 plus or minus rows 0..2).
// Depends on fbc_pkg.
module fbc_plane_store (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [1:0]          wr_row,
	input  fbc_pkg::word_t [3:0] wr_data,
	output fbc_pkg::plane_set_t planes
);
	import fbc_pkg::*;

	matrix_t rows_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= '0;
		end else if (wr_en) begin
			rows_q[wr_row] <= wr_data;
		end
	end

	always_comb begin
		for (int k = 0; k < N_PLANES / 2; k++) begin
			for (int c = 0; c < N_COLS; c++) begin
				planes[2*k][c]   = {rows_q[3][c][COORD_W-1], rows_q[3][c]}
					+ {rows_q[k][c][COORD_W-1], rows_q[k][c]};
				planes[2*k+1][c] = {rows_q[3][c][COORD_W-1], rows_q[3][c]}
					- {rows_q[k][c][COORD_W-1], rows_q[k][c]};
			end
		end
	end

endmodule

// ===== hdl/fbc_dot_pipe.sv =====
// Stages 1 to 3: plane capture, corner select and multiply, partial sums.
// Depends on fbc_pkg.
module fbc_dot_pipe (
	input  logic                   clk,
	input  logic                   arst_n,
	input  fbc_pkg::adv_t          adv,
	input  logic                   take,
	input  fbc_pkg::plane_set_t    planes,
	input  fbc_pkg::box_t          box,
	output fbc_pkg::stage_valid_t  vld,
	output fbc_pkg::psum_set_t     sum_a_s3,
	output fbc_pkg::psum_set_t     sum_b_s3
);
	import fbc_pkg::*;

	plane_set_t                                  planes_s1;
	box_t                                        box_s1;
	logic [N_PLANES-1:0][N_AXES-1:0][PROD_W-1:0] prod_s2;
	logic [N_PLANES-1:0][PLANE_W-1:0]            offs_s2;
	logic [N_PLANES-1:0][N_AXES-1:0][COORD_W-1:0] corner;
	logic [N_PLANES-1:0][N_AXES-1:0][PROD_W-1:0] prod_d;
	psum_set_t                                   sum_a_d;
	psum_set_t                                   sum_b_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			if (adv.en1) vld.v1 <= take;
			if (adv.en2) vld.v2 <= vld.v1;
			if (adv.en3) vld.v3 <= vld.v2;
		end
	end

	always_comb begin
		for (int p = 0; p < N_PLANES; p++) begin
			for (int c = 0; c < N_AXES; c++) begin
				corner[p][c] = planes_s1[p][c][PLANE_W-1] ? box_s1.lo[c] : box_s1.hi[c];
				prod_d[p][c] = PROD_W'($signed(planes_s1[p][c]))
					* PROD_W'($signed(corner[p][c]));
			end
		end
	end

	always_comb begin
		for (int p = 0; p < N_PLANES; p++) begin
			sum_a_d[p] = {prod_s2[p][0][PROD_W-1], prod_s2[p][0]}
				+ {prod_s2[p][1][PROD_W-1], prod_s2[p][1]};
			sum_b_d[p] = {prod_s2[p][2][PROD_W-1], prod_s2[p][2]}
				+ {{(PSUM_W-PLANE_W-FRAC_W){offs_s2[p][PLANE_W-1]}}, offs_s2[p],
					{FRAC_W{1'b0}}};
		end
	end

	always_ff @(posedge clk) begin
		if (adv.en1) begin
			planes_s1 <= planes;
			box_s1    <= box;
		end
		if (adv.en2) begin
			prod_s2 <= prod_d;
			for (int p = 0; p < N_PLANES; p++) begin
				offs_s2[p] <= planes_s1[p][N_COLS-1];
			end
		end
		if (adv.en3) begin
			sum_a_s3 <= sum_a_d;
			sum_b_s3 <= sum_b_d;
		end
	end

endmodule

// ===== hdl/frustum_box_cull_unit.sv =====
// Top level of the frustum box cull unit: handshake control and final sign stage.
// Depends on fbc_pkg, fbc_in_if, fbc_out_if, fbc_plane_store and fbc_dot_pipe.
//
// Usage:
//   item   (sink)   - a transfer with kind = load writes matrix row row_index from
//                     row_coeff_0..3 and produces no result; kind = test carries a
//                     box and produces exactly one result.
//   result (source) - visible = 1 when the box touches the frustum, 0 when culled.
// A load takes effect for every test transferred after it; tests already in flight
// keep the planes they captured.
// Path: a transferred test is captured into stage 1, then passes the multiply,
// partial sums, then final sum and sign into the output register (result.valid).
// Throughput: one item per cycle unless stalled; pipeline stages hold one test each.
// The multiply stage (33 x 32 bit products, eighteen in parallel) sets the cycle.
// Stalls: a stage advances when it is empty or the stage after it advances, so
// bubbles close up and item.ready drops only when all four stages are full and
// result.ready is low. Nothing is lost or repeated under stall.
// Reset: arst_n clears the matrix to zero (every box visible) and empties the pipe.
module frustum_box_cull_unit (
	input  logic      clk,
	input  logic      arst_n,
	fbc_in_if.sink    item,
	fbc_out_if.source result
);
	import fbc_pkg::*;

	adv_t         adv;
	stage_valid_t vld;
	logic         en4;
	logic         xfer;
	logic         load_wr;
	logic         test_take;
	plane_set_t   planes;
	box_t         box;
	word_t [3:0]  row_data;
	psum_set_t    sum_a_s3;
	psum_set_t    sum_b_s3;
	logic [N_PLANES-1:0][TOTAL_W-1:0] total;
	logic [N_PLANES-1:0] below;
	logic         valid_s4;
	logic         visible_s4;

	assign en4     = !valid_s4 || result.ready;
	assign adv.en3 = !vld.v3 || en4;
	assign adv.en2 = !vld.v2 || adv.en3;
	assign adv.en1 = !vld.v1 || adv.en2;

	assign item.ready = adv.en1;
	assign xfer       = item.valid && item.ready;
	assign load_wr    = xfer && (item.kind == KIND_LOAD);
	assign test_take  = xfer && (item.kind == KIND_TEST);

	assign row_data = {item.row_coeff_3, item.row_coeff_2, item.row_coeff_1, item.row_coeff_0};
	assign box.lo   = {item.box_min_z, item.box_min_y, item.box_min_x};
	assign box.hi   = {item.box_max_z, item.box_max_y, item.box_max_x};

	fbc_plane_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (load_wr),
		.wr_row  (item.row_index),
		.wr_data (row_data),
		.planes  (planes)
	);

	fbc_dot_pipe u_dot (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.take     (test_take),
		.planes   (planes),
		.box      (box),
		.vld      (vld),
		.sum_a_s3 (sum_a_s3),
		.sum_b_s3 (sum_b_s3)
	);

	always_comb begin
		for (int p = 0; p < N_PLANES; p++) begin
			total[p] = {sum_a_s3[p][PSUM_W-1], sum_a_s3[p]}
				+ {sum_b_s3[p][PSUM_W-1], sum_b_s3[p]};
			below[p] = total[p][TOTAL_W-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en4) begin
			valid_s4 <= vld.v3;
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			visible_s4 <= ~|below;
		end
	end

	assign result.valid   = valid_s4;
	assign result.visible = visible_s4;

endmodule

// ===== verif/frustum_box_cull_unit_tb.sv =====
// Self-checking testbench for frustum_box_cull_unit: matrix row loads and box tests
// are driven through fbc_in_if and visibility flags are checked as they leave fbc_out_if.
// Depends on fbc_pkg, fbc_in_if, fbc_out_if and the unit itself.
module frustum_box_cull_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fbc_pkg::*;

	localparam int    IDLE_LIMIT    = 400;
	localparam int    RANDOM_ITEMS  = 750;
	localparam int    REPORT_LIMIT  = 10;
	localparam word_t Q_ONE         = 32'h0001_0000;
	localparam word_t Q_HALF        = 32'h0000_8000;
	localparam word_t W_MIN         = 32'h8000_0000;
	localparam word_t W_MAX         = 32'h7fff_ffff;

	typedef struct packed {
		logic                           kind;
		logic [1:0]                     row_index;
		logic [N_COLS-1:0][COORD_W-1:0] coeff;
		logic [N_AXES-1:0][COORD_W-1:0] lo;
		logic [N_AXES-1:0][COORD_W-1:0] hi;
	} cull_item_t;

	logic clk;
	logic arst_n;

	fbc_in_if  item_ch ();
	fbc_out_if result_ch ();

	frustum_box_cull_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	matrix_t view_proj;
	bit      expected_visibility[$];
	int      mismatch_count;
	int      result_count;
	int      idle_cycles;
	int      send_calm;
	int      take_calm;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic bit box_in_frustum(input matrix_t m, input cull_item_t it);
		logic signed [PLANE_W-1:0] pl [N_COLS];
		logic signed [COORD_W-1:0] w;
		logic signed [COORD_W-1:0] v;
		logic signed [COORD_W-1:0] corner;
		logic signed [127:0]       acc;
		bit                        vis;
		vis = 1'b1;
		for (int p = 0; p < N_PLANES; p++) begin
			for (int c = 0; c < N_COLS; c++) begin
				w = m[3][c];
				v = m[p/2][c];
				pl[c] = (p % 2 != 0) ? w - v : w + v;
			end
			acc = '0;
			for (int c = 0; c < N_AXES; c++) begin
				corner = (pl[c] >= 0) ? it.hi[c] : it.lo[c];
				acc = acc + pl[c] * corner;
			end
			acc = acc + pl[3] * 65536;
			if (acc < 0)
				vis = 1'b0;
		end
		return vis;
	endfunction

	function automatic int draw_wait(inout int calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0)
			calm_left = $urandom_range(10, 40);
		return $urandom_range(0, 8);
	endfunction

	function automatic word_t rnd_word();
		case ($urandom_range(0, 5))
			0: return W_MIN;
			1: return W_MAX;
			2: return '0;
			default: return $urandom();
		endcase
	endfunction

	function automatic word_t rnd_span(input int mag);
		return word_t'(int'($urandom_range(0, 2 * mag)) - mag);
	endfunction

	function automatic cull_item_t make_load(input logic [1:0] r, input word_t c0,
			input word_t c1, input word_t c2, input word_t c3);
		cull_item_t it;
		it.kind      = KIND_LOAD;
		it.row_index = r;
		it.coeff     = {c3, c2, c1, c0};
		it.lo        = {$urandom(), $urandom(), $urandom()};
		it.hi        = {$urandom(), $urandom(), $urandom()};
		return it;
	endfunction

	function automatic cull_item_t make_box(input word_t lx, input word_t ly, input word_t lz,
			input word_t hx, input word_t hy, input word_t hz);
		cull_item_t it;
		it.kind      = KIND_TEST;
		it.row_index = 2'($urandom());
		it.coeff     = {$urandom(), $urandom(), $urandom(), $urandom()};
		it.lo        = {lz, ly, lx};
		it.hi        = {hz, hy, hx};
		return it;
	endfunction

	task automatic send_item(input cull_item_t it);
		int gap;
		gap = draw_wait(send_calm);
		if (gap != 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.kind        <= it.kind;
		item_ch.row_index   <= it.row_index;
		item_ch.row_coeff_0 <= it.coeff[0];
		item_ch.row_coeff_1 <= it.coeff[1];
		item_ch.row_coeff_2 <= it.coeff[2];
		item_ch.row_coeff_3 <= it.coeff[3];
		item_ch.box_min_x   <= it.lo[0];
		item_ch.box_min_y   <= it.lo[1];
		item_ch.box_min_z   <= it.lo[2];
		item_ch.box_max_x   <= it.hi[0];
		item_ch.box_max_y   <= it.hi[1];
		item_ch.box_max_z   <= it.hi[2];
		item_ch.valid       <= 1'b1;
		do @(posedge clk); while (!item_ch.ready);
		if (it.kind == KIND_LOAD)
			view_proj[it.row_index] = it.coeff;
		else
			expected_visibility.push_back(box_in_frustum(view_proj, it));
	endtask

	task automatic load_frustum_like();
		word_t r [N_ROWS][N_COLS];
		for (int i = 0; i < N_ROWS; i++)
			for (int c = 0; c < N_COLS; c++)
				r[i][c] = rnd_span(1 << 12);
		for (int i = 0; i < N_AXES; i++)
			r[i][i] = $urandom_range(1 << 14, 1 << 17);
		r[2][3] = rnd_span(1 << 16);
		r[3][3] = $urandom_range(1 << 15, 1 << 17);
		for (int i = 0; i < N_ROWS; i++)
			send_item(make_load(i[1:0], r[i][0], r[i][1], r[i][2], r[i][3]));
	endtask

	task automatic test_zero_matrix();
		send_item(make_box(W_MIN, W_MIN, W_MIN, W_MAX, W_MAX, W_MAX));
		send_item(make_box(W_MAX, W_MAX, W_MAX, W_MIN, W_MIN, W_MIN));
		send_item(make_box('0, '0, '0, '0, '0, '0));
	endtask

	task automatic test_unit_frustum();
		send_item(make_load(2'd0, Q_ONE, '0, '0, '0));
		send_item(make_load(2'd1, '0, Q_ONE, '0, '0));
		send_item(make_load(2'd2, '0, '0, Q_ONE, '0));
		send_item(make_load(2'd3, '0, '0, '0, Q_ONE));
		send_item(make_box(-Q_HALF, -Q_HALF, -Q_HALF, Q_HALF, Q_HALF, Q_HALF));
		send_item(make_box(2 * Q_ONE, -Q_HALF, -Q_HALF, 3 * Q_ONE, Q_HALF, Q_HALF));
		send_item(make_box(-3 * Q_ONE, -Q_HALF, -Q_HALF, -2 * Q_ONE, Q_HALF, Q_HALF));
		send_item(make_box(-Q_HALF, 2 * Q_ONE, -Q_HALF, Q_HALF, 3 * Q_ONE, Q_HALF));
		send_item(make_box(-Q_HALF, -3 * Q_ONE, -Q_HALF, Q_HALF, -2 * Q_ONE, Q_HALF));
		send_item(make_box(-Q_HALF, -Q_HALF, 2 * Q_ONE, Q_HALF, Q_HALF, 3 * Q_ONE));
		send_item(make_box(-Q_HALF, -Q_HALF, -3 * Q_ONE, Q_HALF, Q_HALF, -2 * Q_ONE));
		send_item(make_box(Q_HALF, Q_HALF, Q_HALF, -Q_HALF, -Q_HALF, -Q_HALF));
	endtask

	task automatic test_zero_normal();
		send_item(make_load(2'd0, '0, '0, '0, '0));
		send_item(make_load(2'd1, '0, '0, '0, '0));
		send_item(make_load(2'd2, '0, '0, '0, '0));
		send_item(make_load(2'd3, '0, '0, '0, -Q_ONE));
		send_item(make_box(-Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE));
		send_item(make_load(2'd3, '0, '0, '0, Q_ONE));
		send_item(make_box(-Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE));
	endtask

	task automatic test_extreme_coeffs();
		send_item(make_load(2'd0, W_MIN, W_MIN, W_MIN, W_MIN));
		send_item(make_load(2'd1, W_MAX, W_MAX, W_MAX, W_MAX));
		send_item(make_load(2'd2, W_MIN, W_MAX, W_MIN, W_MAX));
		send_item(make_load(2'd3, W_MAX, W_MAX, W_MAX, W_MAX));
		send_item(make_box(W_MIN, W_MIN, W_MIN, W_MAX, W_MAX, W_MAX));
		send_item(make_box(W_MAX, W_MAX, W_MAX, W_MIN, W_MIN, W_MIN));
		send_item(make_box(W_MAX, W_MIN, W_MAX, W_MAX, W_MIN, W_MAX));
	endtask

	task automatic test_random_stream();
		cull_item_t it;
		word_t      centre;
		word_t      half;
		word_t      tmp;
		int         sel;
		load_frustum_like();
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			sel = $urandom_range(0, 99);
			if (sel < 4) begin
				load_frustum_like();
				n += 3;
			end else if (sel < 8) begin
				send_item(make_load(2'($urandom()), rnd_word(), rnd_word(), rnd_word(),
					rnd_word()));
			end else if (sel < 82) begin
				it = make_box('0, '0, '0, '0, '0, '0);
				for (int a = 0; a < N_AXES; a++) begin
					centre = rnd_span(1 << 17);
					half = $urandom_range(0, 1 << 16);
					it.lo[a] = centre - half;
					it.hi[a] = centre + half;
					if ($urandom_range(0, 15) == 0) begin
						tmp = it.lo[a];
						it.lo[a] = it.hi[a];
						it.hi[a] = tmp;
					end
				end
				send_item(it);
			end else begin
				send_item(make_box(rnd_word(), rnd_word(), rnd_word(),
					rnd_word(), rnd_word(), rnd_word()));
			end
		end
		item_ch.valid <= 1'b0;
	endtask

	initial begin
		int gap;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = draw_wait(take_calm);
			if (gap != 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			result_count++;
			if (expected_visibility.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("result %0d: visible=%0b arrived with nothing pending",
						result_count, result_ch.visible);
			end else if (expected_visibility.pop_front() != result_ch.visible) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("result %0d: expected visible=%0b actual=%0b",
						result_count, !result_ch.visible, result_ch.visible);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else begin
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT) @(posedge clk);
		$display("Verification failed");
		$finish;
	end

	initial begin
		view_proj           = '0;
		send_calm           = 0;
		arst_n              = 1'b0;
		item_ch.valid       = 1'b0;
		item_ch.kind        = KIND_LOAD;
		item_ch.row_index   = '0;
		item_ch.row_coeff_0 = '0;
		item_ch.row_coeff_1 = '0;
		item_ch.row_coeff_2 = '0;
		item_ch.row_coeff_3 = '0;
		item_ch.box_min_x   = '0;
		item_ch.box_min_y   = '0;
		item_ch.box_min_z   = '0;
		item_ch.box_max_x   = '0;
		item_ch.box_max_y   = '0;
		item_ch.box_max_z   = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_zero_matrix();
		test_unit_frustum();
		test_zero_normal();
		test_extreme_coeffs();
		test_random_stream();
		while (expected_visibility.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
